// ----- rtl/core/greedy_box_nms_unit_macros.svh -----
// ----------------------------------------------------------------------------
// greedy_box_nms_unit_macros.svh
// Assertion macros used by the checker of the NMS unit.
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_NMS_UNIT_MACROS_SVH
`define GREEDY_BOX_NMS_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GBN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GBN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/gbn_pkg.sv -----
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared widths, register codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int MAX_KEPT_DEFAULT = 64;

  localparam int COORD_W    = 16;
  localparam int CLASS_W    = 8;
  localparam int AREA_W     = 2 * COORD_W;
  localparam int POS_W      = 7;
  localparam int THR_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [THR_W-1:0] IOU_THR_RESET = 16'd29491;  // 0.45 over 65536

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_AGNOSTIC = 1'd1;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic [COORD_W-1:0]        width;
    logic [COORD_W-1:0]        height;
    logic [CLASS_W-1:0]        cls;
    logic [AREA_W-1:0]         area;
  } entry_t;

  typedef struct packed {
    logic capture;  // latch the incoming box, start a scan
    logic issue;    // read the next kept entry into the compare pipe
    logic commit;   // store if kept and there is room, load the result register
  } cmd_t;

  typedef struct packed {
    logic scan_done;  // every kept entry has been issued
    logic pipe_busy;  // compares still in flight
    logic out_free;   // result register can take a new beat
  } sts_t;

endpackage

// ----- rtl/core/gbn_ctrl.sv -----
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer: capture a box, scan the kept store, drain, commit the result.
// ----------------------------------------------------------------------------
module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (sts.scan_done && !sts.pipe_busy) state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (sts.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready    = (state == ST_IDLE);
  assign cmd.capture = (state == ST_IDLE) && in_valid;
  assign cmd.issue   = (state == ST_SCAN) && !sts.scan_done;
  assign cmd.commit  = (state == ST_COMMIT) && sts.out_free;

endmodule

// ----- rtl/core/gbn_datapath.sv -----
// ----------------------------------------------------------------------------
// gbn_datapath
// Kept-box store, one-compare-per-cycle IoU pipe, config and result regs.
// ----------------------------------------------------------------------------
module gbn_datapath
  import gbn_pkg::*;
#(
  parameter int MAX_KEPT = MAX_KEPT_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      first_of_frame,
  input  logic signed [COORD_W-1:0] box_left,
  input  logic signed [COORD_W-1:0] box_top,
  input  logic [COORD_W-1:0]        box_width,
  input  logic [COORD_W-1:0]        box_height,
  input  logic [CLASS_W-1:0]        class_label,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      keep,
  output logic [POS_W-1:0]          kept_position,
  output logic                      store_overflow,
  input  cmd_t                      cmd,
  output sts_t                      sts
);

  localparam int CW = $clog2(MAX_KEPT + 1);
  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  // overlap of [a0, a0+al) and [b0, b0+bl), zero when disjoint
  function automatic logic [COORD_W-1:0] overlap(
    input logic signed [COORD_W-1:0] a0,
    input logic [COORD_W-1:0]        al,
    input logic signed [COORD_W-1:0] b0,
    input logic [COORD_W-1:0]        bl
  );
    logic signed [COORD_W+1:0] a0x, b0x, a1, b1, lo, hi, diff;
    a0x  = {{2{a0[COORD_W-1]}}, a0};
    b0x  = {{2{b0[COORD_W-1]}}, b0};
    a1   = a0x + $signed({2'b00, al});
    b1   = b0x + $signed({2'b00, bl});
    lo   = (a0x > b0x) ? a0x : b0x;
    hi   = (a1 < b1) ? a1 : b1;
    diff = hi - lo;
    return (hi > lo) ? diff[COORD_W-1:0] : '0;
  endfunction

  logic [THR_W-1:0] iou_threshold;
  logic             class_agnostic;

  // current box
  entry_t box;

  entry_t           mem [MAX_KEPT];
  logic [CW-1:0]    count;
  logic [CW-1:0]    ptr;
  logic             room;

  // compare pipe
  entry_t              rd_q;
  logic                v1, v2, v3, v4, v5;
  logic [COORD_W-1:0]  ox2, oy2;
  logic [AREA_W-1:0]   karea2, karea3;
  logic [AREA_W-1:0]   inter3, inter4, inter5;
  logic [AREA_W:0]     uni4;
  logic [THR_W+AREA_W:0] prod5;
  logic                suppress;

  assign room = (count < CW'(MAX_KEPT));

  always_ff @(posedge clk) begin
    if (rst) begin
      iou_threshold  <= IOU_THR_RESET;
      class_agnostic <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IOU_THRESHOLD:  iou_threshold  <= cfg_data[THR_W-1:0];
        REG_CLASS_AGNOSTIC: class_agnostic <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      box.left   <= box_left;
      box.top    <= box_top;
      box.width  <= box_width;
      box.height <= box_height;
      box.cls    <= class_label;
      box.area   <= box_width * box_height;
    end
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit && !suppress && room) mem[count[AW-1:0]] <= box;
    if (cmd.issue) rd_q <= mem[ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
    end else begin
      if (cmd.capture) begin
        ptr <= '0;
        if (first_of_frame) count <= '0;
      end else if (cmd.issue) begin
        ptr <= ptr + 1'b1;
      end
      if (cmd.commit && !suppress && room) count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      suppress <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1 && (class_agnostic || (rd_q.cls == box.cls));
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      if (cmd.capture) begin
        suppress <= 1'b0;
      end else if (v5 && ({1'b0, inter5, {THR_W{1'b0}}} > prod5)) begin
        suppress <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ox2    <= overlap(box.left, box.width, rd_q.left, rd_q.width);
    oy2    <= overlap(box.top, box.height, rd_q.top, rd_q.height);
    karea2 <= rd_q.area;
    inter3 <= ox2 * oy2;
    karea3 <= karea2;
    uni4   <= {1'b0, box.area} + {1'b0, karea3} - {1'b0, inter3};
    inter4 <= inter3;
    prod5  <= iou_threshold * uni4;
    inter5 <= inter4;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      keep           <= !suppress;
      kept_position  <= POS_W'(count);
      store_overflow <= !suppress && !room;
    end
  end

  assign sts.scan_done = (ptr == count);
  assign sts.pipe_busy = v1 || v2 || v3 || v4 || v5;
  assign sts.out_free  = !out_valid || out_ready;

endmodule

// ----- rtl/core/greedy_box_nms_unit.sv -----
// Boxes are taken one at a time; the store is read one entry per cycle into
//   the compare pipe, and trailing other-class entries drain early.
// A stalled result beat holds back the commit.
// Reset: synchronous; clears kept count, config to defaults, no beat pending.
// ----------------------------------------------------------------------------
// greedy_box_nms_unit
// Greedy IoU non-maximum suppression over score-sorted detection boxes.
// ----------------------------------------------------------------------------
//
// Each accepted box is scanned against every entry of the kept store. The
// store is one memory of MAX_KEPT entries (box, class, precomputed area),
// read once per cycle. Per entry the pipe computes:
//   stage 1  registered store read
//   stage 2  x and y overlap lengths, class match (or agnostic mode)
//   stage 3  inter = ox * oy
//   stage 4  union = area + kept_area - inter
//   stage 5  threshold * union
//   stage 6  sticky suppress if inter * 65536 > threshold * union
// Entries from a different class simply drop out of the pipe. After the pipe
// drains, a surviving box is written at the kept count if there is room;
// otherwise it is reported with store_overflow. kept_position is the count
// before this box, for suppressed boxes as well.
//
// first_of_frame empties the store by clearing the count at capture; stale
// entries above the count are never read, so the store needs no clearing.
//
// A new box is taken while the previous result beat still waits on the
// output register; the commit then waits until that beat leaves.
// Config writes are expected only while no box is in flight.
module greedy_box_nms_unit
  import gbn_pkg::*;
#(
  parameter int MAX_KEPT = MAX_KEPT_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  // box input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      first_of_frame,
  input  logic signed [COORD_W-1:0] box_left,
  input  logic signed [COORD_W-1:0] box_top,
  input  logic [COORD_W-1:0]        box_width,
  input  logic [COORD_W-1:0]        box_height,
  input  logic [CLASS_W-1:0]        class_label,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      keep,
  output logic [POS_W-1:0]          kept_position,
  output logic                      store_overflow
);

  cmd_t cmd;
  sts_t sts;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbn_datapath #(
    .MAX_KEPT (MAX_KEPT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .first_of_frame (first_of_frame),
    .box_left       (box_left),
    .box_top        (box_top),
    .box_width      (box_width),
    .box_height     (box_height),
    .class_label    (class_label),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .keep           (keep),
    .kept_position  (kept_position),
    .store_overflow (store_overflow),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ----- rtl/core/gbn_checker.sv -----
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks of the NMS unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "greedy_box_nms_unit_macros.svh"

module gbn_checker
  import gbn_pkg::*;
#(
  parameter int MAX_KEPT = MAX_KEPT_DEFAULT
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             keep,
  input logic [POS_W-1:0] kept_position,
  input logic             store_overflow
);

  // stalled result beat holds
  `GBN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({keep, kept_position, store_overflow}), "result beat changed while stalled")

  // overflow is only reported for a kept box
  `GBN_ASSERT_NOW(a_ovf_keep, out_valid && store_overflow, keep, "overflow on suppressed box")

  // overflow means the store was full
  `GBN_ASSERT_NOW(a_ovf_pos, out_valid && store_overflow, kept_position == POS_W'(MAX_KEPT), "overflow with store not full")

  // one box in flight at a time
  `GBN_ASSERT_NEXT(a_one_box, in_valid && in_ready, !in_ready, "second box taken during scan")

endmodule

bind greedy_box_nms_unit gbn_checker #(
  .MAX_KEPT (MAX_KEPT)
) u_gbn_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .keep           (keep),
  .kept_position  (kept_position),
  .store_overflow (store_overflow)
);

// ----- test/greedy_box_nms_unit_tb.sv -----
// ----------------------------------------------------------------------------
// greedy_box_nms_unit_tb
// Self-checking bench for the greedy IoU suppression unit. A table of
// directed boxes is followed by random frames under several threshold and
// class-mode settings. Each beat is checked against a model or typed verdict.
// ----------------------------------------------------------------------------
module greedy_box_nms_unit_tb;
  import gbn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_KEPT    = MAX_KEPT_DEFAULT;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 8;
  localparam int PHASE_BOXES = 144;
  localparam int MAX_GAP     = 18;

  // One box on the input channel, plus its start-of-frame mark.
  typedef struct packed {
    logic                      sof;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic [COORD_W-1:0]        width;
    logic [COORD_W-1:0]        height;
    logic [CLASS_W-1:0]        cls;
  } box_t;

  // One result beat.
  typedef struct packed {
    logic             keep;
    logic [POS_W-1:0] pos;
    logic             ovf;
  } verdict_t;

  // Directed row: a box, and where obvious, the verdict typed in by hand.
  typedef struct packed {
    box_t     b;
    logic     typed;
    verdict_t v;
  } row_t;

  // --------------------------------------------------------------------------
  // DUT signals, inputs at known values from time zero
  // --------------------------------------------------------------------------
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      first_of_frame = 1'b0;
  logic signed [COORD_W-1:0] box_left = '0;
  logic signed [COORD_W-1:0] box_top = '0;
  logic [COORD_W-1:0]        box_width = '0;
  logic [COORD_W-1:0]        box_height = '0;
  logic [CLASS_W-1:0]        class_label = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      keep;
  logic [POS_W-1:0]          kept_position;
  logic                      store_overflow;

  greedy_box_nms_unit #(.MAX_KEPT(MAX_KEPT)) uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .first_of_frame (first_of_frame),
    .box_left       (box_left),
    .box_top        (box_top),
    .box_width      (box_width),
    .box_height     (box_height),
    .class_label    (class_label),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .keep           (keep),
    .kept_position  (kept_position),
    .store_overflow (store_overflow)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Local copy of the unit state, used to predict every verdict
  // --------------------------------------------------------------------------
  logic [THR_W-1:0] thr_cfg = IOU_THR_RESET;
  logic             agn_cfg = 1'b0;
  box_t             kept_box  [MAX_KEPT];
  longint           kept_area [MAX_KEPT];
  int               kept_n = 0;

  verdict_t pending_verdicts[$];

  int  errors = 0;
  int  cycle_cnt = 0;
  int  n_boxes = 0;
  int  n_frames = 0;
  int  n_settings = 0;
  int  n_kept = 0;
  int  n_suppressed = 0;
  int  n_overflow = 0;
  bit  tx_quiet = 1'b0;
  bit  rx_quiet = 1'b0;

  // Overlap of the half-open spans [a0, a0+al) and [b0, b0+bl).
  function automatic longint span_overlap(longint a0, longint al, longint b0, longint bl);
    longint lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // Greedy suppression of one box against the kept store; updates the store.
  function automatic verdict_t judge_box(box_t b);
    verdict_t v;
    longint   area, inter, uni;
    bit       survives;
    survives = 1'b1;
    if (b.sof) kept_n = 0;
    v.pos = kept_n[POS_W-1:0];
    area = longint'(b.width) * longint'(b.height);
    for (int j = 0; j < kept_n; j++) begin
      if (agn_cfg || kept_box[j].cls == b.cls) begin
        inter = span_overlap(longint'($signed(b.left)), longint'(b.width),
                             longint'($signed(kept_box[j].left)),
                             longint'(kept_box[j].width)) *
                span_overlap(longint'($signed(b.top)), longint'(b.height),
                             longint'($signed(kept_box[j].top)),
                             longint'(kept_box[j].height));
        uni = area + kept_area[j] - inter;
        // strict test: IoU above threshold, no division
        if ((inter << 16) > longint'(thr_cfg) * uni) survives = 1'b0;
      end
    end
    v.keep = survives;
    v.ovf  = 1'b0;
    if (survives) begin
      if (kept_n < MAX_KEPT) begin
        kept_box[kept_n]  = b;
        kept_area[kept_n] = area;
        kept_n++;
      end else begin
        v.ovf = 1'b1;
      end
    end
    return v;
  endfunction

  // Random box: either a jittered copy of a kept box (so that overlaps are
  // common) or a fresh box, mostly small and spread over the whole plane.
  function automatic box_t make_box(bit sof);
    box_t b, src;
    int   j, span;
    b.sof = sof;
    if (!sof && kept_n > 0 && $urandom_range(0, 99) < 40) begin
      j    = $urandom_range(0, kept_n - 1);
      src  = kept_box[j];
      span = int'(src.width) / 2 + 1;
      b.left   = src.left + 16'(int'($urandom_range(0, 2 * span)) - span);
      span = int'(src.height) / 2 + 1;
      b.top    = src.top + 16'(int'($urandom_range(0, 2 * span)) - span);
      b.width  = src.width + 16'(int'($urandom_range(0, 64)) - 32);
      b.height = src.height + 16'(int'($urandom_range(0, 64)) - 32);
      b.cls    = ($urandom_range(0, 4) != 0) ? src.cls : 8'($urandom_range(0, 255));
    end else begin
      b.left = 16'($urandom());
      b.top  = 16'($urandom());
      case ($urandom_range(0, 19))
        0, 1:    b.width = 16'($urandom_range(0, 65535));
        2:       b.width = '0;
        default: b.width = 16'($urandom_range(1, 1023));
      endcase
      case ($urandom_range(0, 19))
        0, 1:    b.height = 16'($urandom_range(0, 65535));
        2:       b.height = '0;
        default: b.height = 16'($urandom_range(1, 1023));
      endcase
      b.cls = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 3));
    end
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: drive one beat after a random gap, predict on acceptance
  // --------------------------------------------------------------------------
  task automatic push_box(input box_t b, input bit typed, input verdict_t typed_v);
    int       gap;
    verdict_t v;
    if ($urandom_range(0, 29) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    first_of_frame <= b.sof;
    box_left       <= b.left;
    box_top        <= b.top;
    box_width      <= b.width;
    box_height     <= b.height;
    class_label    <= b.cls;
    do @(posedge clk); while (!in_ready);
    // prediction runs even for typed rows, to keep the store in step
    v = judge_box(b);
    if (typed) v = typed_v;
    pending_verdicts = {pending_verdicts, v};
    n_boxes++;
    if (b.sof) n_frames++;
    if (!v.keep) n_suppressed++;
    else if (v.ovf) n_overflow++;
    else n_kept++;
  endtask

  // Hold the input idle until every predicted beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  // Both registers, back to back; only called with the unit idle.
  task automatic load_settings(input logic [THR_W-1:0] thr, input logic agn);
    cfg_write <= 1'b1;
    cfg_index <= REG_IOU_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= REG_CLASS_AGNOSTIC;
    cfg_data  <= CFG_DATA_W'(agn);
    @(posedge clk);
    cfg_write <= 1'b0;
    thr_cfg = thr;
    agn_cfg = agn;
    n_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Directed table, walked with the reset settings (threshold 0.45, per class)
  // --------------------------------------------------------------------------
  localparam int N_ROWS = 18;
  row_t directed_rows [N_ROWS] = '{
    // first box after reset
    '{'{1'b1, 16'sh0000, 16'sh0000, 16'd256, 16'd256, 8'd0}, 1'b1, '{1'b1, 7'd0, 1'b0}},
    // identical box, same class: IoU of one
    '{'{1'b0, 16'sh0000, 16'sh0000, 16'd256, 16'd256, 8'd0}, 1'b1, '{1'b0, 7'd1, 1'b0}},
    // identical box, other class
    '{'{1'b0, 16'sh0000, 16'sh0000, 16'd256, 16'd256, 8'd1}, 1'b1, '{1'b1, 7'd1, 1'b0}},
    // touching on the right, then below
    '{'{1'b0, 16'sh0100, 16'sh0000, 16'd256, 16'd256, 8'd0}, 1'b1, '{1'b1, 7'd2, 1'b0}},
    '{'{1'b0, 16'sh0000, 16'sh0100, 16'd256, 16'd256, 8'd0}, 1'b1, '{1'b1, 7'd3, 1'b0}},
    // far corner, disjoint
    '{'{1'b0, 16'sh8000, 16'sh8000, 16'd16, 16'd16, 8'd0}, 1'b1, '{1'b1, 7'd4, 1'b0}},
    // empty box, then a second one: zero union
    '{'{1'b0, 16'sh0000, 16'sh0000, 16'd0, 16'd0, 8'd0}, 1'b1, '{1'b1, 7'd5, 1'b0}},
    '{'{1'b0, 16'sh0000, 16'sh0000, 16'd0, 16'd0, 8'd0}, 1'b1, '{1'b1, 7'd6, 1'b0}},
    // largest boxes at both coordinate extremes, touching at one corner
    '{'{1'b0, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1, '{1'b1, 7'd7, 1'b0}},
    '{'{1'b0, 16'sh8000, 16'sh8000, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1, '{1'b1, 7'd8, 1'b0}},
    '{'{1'b0, 16'sh8000, 16'sh8000, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1, '{1'b0, 7'd9, 1'b0}},
    // partial overlaps, left to the model
    '{'{1'b0, 16'sh0040, 16'sh0000, 16'd256, 16'd256, 8'd0}, 1'b0, '0},
    '{'{1'b0, 16'sh0080, 16'sh0000, 16'd256, 16'd256, 8'd0}, 1'b0, '0},
    '{'{1'b0, 16'sh5555, 16'shAAAA, 16'hAAAA, 16'h5555, 8'hAA}, 1'b0, '0},
    '{'{1'b0, 16'shAAAA, 16'sh5555, 16'h5555, 16'hAAAA, 8'h55}, 1'b0, '0},
    // new frame empties the store
    '{'{1'b1, 16'sh0000, 16'sh0000, 16'd256, 16'd256, 8'd0}, 1'b1, '{1'b1, 7'd0, 1'b0}},
    '{'{1'b0, 16'sh0001, 16'sh0001, 16'd256, 16'd256, 8'd0}, 1'b0, '0},
    '{'{1'b0, 16'shFFFF, 16'shFFFF, 16'd1, 16'd1, 8'hFF}, 1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed table, then random frames per setting
  // --------------------------------------------------------------------------
  initial begin
    logic [THR_W-1:0] thr;
    logic             agn;
    int               sent, len, k;
    bit               carry_frame;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < N_ROWS; r++)
      push_box(directed_rows[r].b, directed_rows[r].typed, directed_rows[r].v);

    for (int ph = 0; ph < PHASES; ph++) begin
      // settings change only with nothing in flight
      drain();
      case (ph)
        0:       begin thr = '0;                        agn = 1'b0; end
        1:       begin thr = '1;                        agn = 1'b1; end
        2:       begin thr = IOU_THR_RESET;             agn = 1'b1; end
        3:       begin thr = 16'($urandom_range(0, 65535)); agn = 1'b0; end
        4:       begin thr = '0;                        agn = 1'b1; end
        5:       begin thr = '1;                        agn = 1'b0; end
        6:       begin thr = 16'($urandom_range(0, 65535)); agn = 1'($urandom_range(0, 1)); end
        default: begin thr = 16'h8000;                  agn = 1'b0; end
      endcase
      load_settings(thr, agn);

      // the kept store survives a settings change; sometimes keep the frame
      carry_frame = ($urandom_range(0, 1) == 0);
      sent = 0;
      while (sent < PHASE_BOXES) begin
        // mostly short frames; long ones run past a full store
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 30) : $urandom_range(60, 100);
        for (k = 0; k < len && sent < PHASE_BOXES; k++) begin
          push_box(make_box(k == 0 && !carry_frame), 1'b0, '0);
          sent++;
          // now and then let the unit run completely dry
          if ($urandom_range(0, 79) == 0) drain();
        end
        carry_frame = 1'b0;
      end
    end

    drain();
    // trailing window: anything arriving now is unexpected
    repeat (2 * (MAX_KEPT + 8)) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted beats never arrived", $time, pending_verdicts.size());
    end

    $display("Covered %0d boxes in %0d frames under %0d register settings",
             n_boxes, n_frames, n_settings + 1);
    $display("  %0d kept, %0d suppressed, %0d kept with the store full",
             n_kept, n_suppressed, n_overflow);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, sometimes long runs with none
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    forever begin
      if ($urandom_range(0, 29) == 0) rx_quiet = !rx_quiet;
      gap = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Each result beat against the oldest prediction, field by field.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected: keep=%0b pos=%0d ovf=%0b",
                 $time, keep, kept_position, store_overflow);
      end else begin
        want = pending_verdicts.pop_front();
        if (keep !== want.keep) begin
          errors++;
          $display("%0t: keep expected %0b actual %0b", $time, want.keep, keep);
        end
        if (kept_position !== want.pos) begin
          errors++;
          $display("%0t: kept_position expected %0d actual %0d",
                   $time, want.pos, kept_position);
        end
        if (store_overflow !== want.ovf) begin
          errors++;
          $display("%0t: store_overflow expected %0b actual %0b",
                   $time, want.ovf, store_overflow);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d beats outstanding",
               $time, cycle_cnt, pending_verdicts.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
